### sv/serial_frame_receiver_macros.svh
// Assertion macros shared by the serial frame receiver RTL.
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off during reset.
`define SFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("serial_frame_receiver: check failed");
// Next-cycle implication, sampled on i_clk, off during reset.
`define SFR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("serial_frame_receiver: check failed");
`else
`define SFR_ASSERT_IMP(label, ante, cons)
`define SFR_ASSERT_NXT(label, ante, cons)
`endif

`endif

### sv/sfr_pkg.sv
// Types, constants and helpers for the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int FIELD_BYTES_DEF    = 11;
    localparam int APP_NAME_BYTES_DEF = 9;

    localparam logic [7:0]  MARKER_BYTE   = 8'd221;
    localparam logic [13:0] SUM_LIMIT     = 14'd10000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic        KIND_RESET    = 1'b1;

    localparam logic [4:0] DATA_LEN    = 5'd4;
    localparam logic [4:0] NETDATA_LEN = 5'd7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_KIND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

    typedef enum logic [2:0] {
        EV_PAYLOAD = 3'd0,
        EV_APP     = 3'd1,
        EV_GOOD    = 3'd2,
        EV_BAD     = 3'd3,
        EV_TIMEOUT = 3'd4
    } t_event;

    // Expected tag character: NETDATA when kind is set, else DATA.
    function automatic logic [7:0] tag_char(input logic kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (kind) begin
            unique case (pos)
                3'd0: ch = "N";
                3'd1: ch = "E";
                3'd2: ch = "T";
                3'd3: ch = "D";
                3'd4: ch = "A";
                3'd5: ch = "T";
                3'd6: ch = "A";
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (pos)
                3'd0: ch = "D";
                3'd1: ch = "A";
                3'd2: ch = "T";
                3'd3: ch = "A";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

### sv/sfr_if.sv
// Valid/ready channel interfaces for input, result and configuration requests.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [31:0] frame_length;

    modport source (output valid, output event_res, output data_byte,
                    output frame_length, input ready);
    modport sink   (input valid, input event_res, input data_byte,
                    input frame_length, output ready);
endinterface

interface sfr_cfg_if;
    import sfr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/serial_frame_receiver.sv
// Serial frame receiver top level: deframer, checksum and timeout logic.
// Takes one request per cycle while the output is not stalled, either a received
// byte or a millisecond tick, and gives at most one result per request. A request
// lands in an input register, combinational logic updates the frame state, and
// any result goes to an output register. A result waiting at the output does not
// block the input: the input register still takes one more request, and only a
// request that would produce another result holds there until the output drains.
// The sustained rate is one request per clock while no result waits on a stalled
// output, set by the single state update per cycle. Configuration writes are taken
// every cycle and read live.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_frame_receiver_macros.svh"

module serial_frame_receiver #(
    parameter int FIELD_BYTES    = sfr_pkg::FIELD_BYTES_DEF,
    parameter int APP_NAME_BYTES = sfr_pkg::APP_NAME_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sfr_in_if.sink      i_in,
    sfr_out_if.source   o_out,
    sfr_cfg_if.sink     i_cfg
);
    import sfr_pkg::*;

    localparam int FC_W = $clog2(FIELD_BYTES);
    localparam logic [FC_W-1:0] FIELD_LAST = FC_W'(FIELD_BYTES - 1);
    localparam logic [5:0]      APP_LIMIT  = 6'(APP_NAME_BYTES);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TAG     = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_SUM     = 3'd3;
    localparam logic [2:0] PH_APP     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_VERDICT = 3'd6;

    // Configuration registers
    logic        r_frame_kind;
    logic [15:0] r_timeout_ms;

    // Input register
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;

    // Frame state
    logic [2:0]      r_phase,        n_phase;
    logic [FC_W-1:0] r_field_chars,  n_field_chars;
    logic            r_tag_mismatch, n_tag_mismatch;
    logic            r_num_ended,    n_num_ended;
    logic [31:0]     r_acc,          n_acc;
    logic [31:0]     r_declared_len, n_declared_len;
    logic [31:0]     r_expected_sum, n_expected_sum;
    logic [13:0]     r_running_sum,  n_running_sum;
    logic [31:0]     r_payload_cnt,  n_payload_cnt;
    logic [15:0]     r_elapsed_ms,   n_elapsed_ms;

    // Result register
    logic        r_out_valid;
    t_event      r_out_event;
    logic [7:0]  r_out_data;
    logic [31:0] r_out_len;

    logic        w_has_res;
    t_event      w_event;
    logic [7:0]  w_data;
    logic [31:0] w_len;
    logic        w_take;

    logic        w_tick;
    logic [7:0]  w_c;
    logic        w_field_end;
    logic [4:0]  w_need;
    logic [4:0]  w_pos;
    logic [14:0] w_sum_add;
    logic [31:0] w_exp_next;

    assign w_tick      = r_in_cmd;
    assign w_c         = r_in_byte;
    assign w_field_end = (w_c == 8'd0) || (r_field_chars >= FIELD_LAST);
    assign w_need      = r_frame_kind ? NETDATA_LEN : DATA_LEN;
    assign w_pos       = 5'(r_field_chars);
    assign w_sum_add   = 15'(r_running_sum) + 15'(w_c);
    assign w_exp_next  = (r_phase == PH_SUM) ? r_acc : r_expected_sum;

    // Advance the input register unless its result would overwrite a waiting one.
    assign w_take     = r_in_valid && (!w_has_res || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_take;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_out_event;
    assign o_out.data_byte    = r_out_data;
    assign o_out.frame_length = r_out_len;

    always_comb begin
        n_phase        = r_phase;
        n_field_chars  = r_field_chars;
        n_tag_mismatch = r_tag_mismatch;
        n_num_ended    = r_num_ended;
        n_acc          = r_acc;
        n_declared_len = r_declared_len;
        n_expected_sum = r_expected_sum;
        n_running_sum  = r_running_sum;
        n_payload_cnt  = r_payload_cnt;
        n_elapsed_ms   = r_elapsed_ms;
        w_has_res      = 1'b0;
        w_event        = EV_PAYLOAD;
        w_data         = 8'd0;
        w_len          = 32'd0;

        priority if (r_phase == PH_VERDICT) begin
            // Give the held verdict; a marker here opens the next frame.
            n_phase   = PH_HUNT;
            w_has_res = 1'b1;
            w_event   = (r_expected_sum == 32'(r_running_sum)) ? EV_GOOD : EV_BAD;
            w_len     = r_declared_len;
            if (!w_tick && (w_c == MARKER_BYTE)) begin
                n_elapsed_ms   = 16'd0;
                n_phase        = PH_TAG;
                n_field_chars  = '0;
                n_tag_mismatch = 1'b0;
                n_acc          = 32'd0;
                n_num_ended    = 1'b0;
            end
        end else if (w_tick) begin
            if (r_phase != PH_HUNT) begin
                if (r_elapsed_ms != 16'hFFFF) begin
                    n_elapsed_ms = r_elapsed_ms + 16'd1;
                end
                if (n_elapsed_ms >= r_timeout_ms) begin
                    n_phase   = PH_HUNT;
                    w_has_res = 1'b1;
                    w_event   = EV_TIMEOUT;
                    w_len     = r_declared_len;
                end
            end
        end else if (r_phase == PH_HUNT) begin
            if (w_c == MARKER_BYTE) begin
                n_elapsed_ms   = 16'd0;
                n_declared_len = 32'd0;
                n_expected_sum = 32'd0;
                n_phase        = PH_TAG;
                n_field_chars  = '0;
                n_tag_mismatch = 1'b0;
                n_acc          = 32'd0;
                n_num_ended    = 1'b0;
            end
        end else if (r_phase == PH_PAYLOAD) begin
            // Reduce once: the sum stays below twice the limit.
            if (w_sum_add > 15'(SUM_LIMIT)) begin
                n_running_sum = 14'(w_sum_add - 15'(SUM_LIMIT));
            end else begin
                n_running_sum = 14'(w_sum_add);
            end
            n_payload_cnt = r_payload_cnt + 32'd1;
            if (n_payload_cnt >= r_declared_len) begin
                n_phase = PH_VERDICT;
            end
            w_has_res = 1'b1;
            w_event   = EV_PAYLOAD;
            w_data    = w_c;
        end else if ((r_phase == PH_TAG) || (r_phase == PH_LEN) ||
                     (r_phase == PH_SUM) || (r_phase == PH_APP)) begin
            if (w_field_end) begin
                if (r_phase == PH_TAG) begin
                    if (r_tag_mismatch || (w_pos < w_need)) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end else if (r_phase == PH_LEN) begin
                    n_declared_len = r_acc;
                    n_phase        = PH_SUM;
                end else if ((r_phase == PH_SUM) && r_frame_kind) begin
                    n_expected_sum = r_acc;
                    n_phase        = PH_APP;
                end else begin
                    // Header done: start the payload, or close a zero-length frame.
                    n_expected_sum = w_exp_next;
                    n_elapsed_ms   = 16'd0;
                    n_running_sum  = 14'd0;
                    n_payload_cnt  = 32'd0;
                    if (r_declared_len == 32'd0) begin
                        n_phase   = PH_HUNT;
                        w_has_res = 1'b1;
                        w_event   = (w_exp_next == 32'd0) ? EV_GOOD : EV_BAD;
                        w_len     = r_declared_len;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                // Field start clears the per-field state.
                n_field_chars  = '0;
                n_tag_mismatch = 1'b0;
                n_acc          = 32'd0;
                n_num_ended    = 1'b0;
            end else begin
                n_field_chars = r_field_chars + FC_W'(1);
                if (r_phase == PH_TAG) begin
                    if ((w_pos < w_need) && (tag_char(r_frame_kind, w_pos[2:0]) != w_c)) begin
                        n_tag_mismatch = 1'b1;
                    end
                end else if (r_phase == PH_APP) begin
                    if (6'(w_pos) < APP_LIMIT) begin
                        w_has_res = 1'b1;
                        w_event   = EV_APP;
                        w_data    = w_c;
                    end
                end else if (!r_num_ended && (w_c >= "0") && (w_c <= "9")) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + 32'(w_c - 8'd48);
                end else begin
                    n_num_ended = 1'b1;
                end
            end
        end else begin
            n_phase = PH_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_kind <= KIND_RESET;
            r_timeout_ms <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_KIND: r_frame_kind <= i_cfg.data[0];
                CFG_TIMEOUT:    r_timeout_ms <= i_cfg.data[15:0];
                default:        r_timeout_ms <= r_timeout_ms;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd  <= i_in.cmd;
            r_in_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_field_chars  <= '0;
            r_tag_mismatch <= 1'b0;
            r_num_ended    <= 1'b0;
            r_acc          <= 32'd0;
            r_declared_len <= 32'd0;
            r_expected_sum <= 32'd0;
            r_running_sum  <= 14'd0;
            r_payload_cnt  <= 32'd0;
            r_elapsed_ms   <= 16'd0;
        end else if (w_take) begin
            r_phase        <= n_phase;
            r_field_chars  <= n_field_chars;
            r_tag_mismatch <= n_tag_mismatch;
            r_num_ended    <= n_num_ended;
            r_acc          <= n_acc;
            r_declared_len <= n_declared_len;
            r_expected_sum <= n_expected_sum;
            r_running_sum  <= n_running_sum;
            r_payload_cnt  <= n_payload_cnt;
            r_elapsed_ms   <= n_elapsed_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_has_res) begin
            r_out_event <= w_event;
            r_out_data  <= w_data;
            r_out_len   <= w_len;
        end
    end

    `SFR_ASSERT_IMP(a_sum_in_range, 1'b1, r_running_sum <= SUM_LIMIT)
    `SFR_ASSERT_IMP(a_field_bound, 1'b1, r_field_chars <= FIELD_LAST)
    `SFR_ASSERT_IMP(a_verdict_count, r_phase == PH_VERDICT, r_payload_cnt >= r_declared_len)
    `SFR_ASSERT_IMP(a_byte_event_len, r_out_valid && (r_out_event == EV_PAYLOAD || r_out_event == EV_APP), r_out_len == 32'd0)
    `SFR_ASSERT_NXT(a_wait_holds_input, r_in_valid && !w_take, r_in_valid)

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for serial_frame_receiver, which predicts results with a local deframer.
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    localparam int FIELD_MAX    = FIELD_BYTES_DEF;
    localparam int APP_MAX      = APP_NAME_BYTES_DEF;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_MAX   = 10;

    localparam logic [55:0] NETDATA_WORD = "NETDATA";
    localparam logic [31:0] DATA_WORD    = "DATA";
    localparam logic [7:0]  CH_ZERO      = "0";
    localparam logic [7:0]  CH_NINE      = "9";

    typedef enum logic [2:0] {
        RX_HUNT, RX_TAG, RX_LEN, RX_SUM, RX_APP, RX_PAYLOAD, RX_VERDICT
    } t_rx_phase;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [31:0] len;
    } t_rx_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // deframer state and live copy of the registers
    logic        kind_reg    = KIND_RESET;
    logic [15:0] timeout_reg = TIMEOUT_RESET;
    t_rx_phase   rx_phase    = RX_HUNT;
    int unsigned field_cnt   = 0;
    logic        tag_bad     = 1'b0;
    logic        num_done    = 1'b0;
    logic [31:0] num_acc     = '0;
    logic [31:0] frame_len   = '0;
    logic [31:0] frame_sum   = '0;
    logic [13:0] pay_sum     = '0;
    logic [31:0] pay_cnt     = '0;
    logic [15:0] elapsed     = '0;

    t_rx_result  expected_q[$];
    int unsigned req_cnt, frame_cnt, result_cnt, err_cnt, cycle_cnt;
    int unsigned good_cnt, bad_cnt, tmo_cnt;
    int unsigned hold_cnt;
    logic        send_idle_on  = 1'b1;
    logic        recv_stall_on = 1'b1;

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();
    sfr_cfg_if cfg_ch ();

    serial_frame_receiver i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     expected_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- deframer

    function automatic void open_field(input t_rx_phase next);
        rx_phase  = next;
        field_cnt = 0;
        tag_bad   = 1'b0;
        num_acc   = '0;
        num_done  = 1'b0;
    endfunction

    function automatic t_event checksum_event();
        return (frame_sum == {18'd0, pay_sum}) ? EV_GOOD : EV_BAD;
    endfunction

    function automatic bit begin_payload(output t_rx_result res);
        res     = '{ev: EV_PAYLOAD, data: 8'h00, len: 32'h0};
        elapsed = '0;
        pay_sum = '0;
        pay_cnt = '0;
        // zero length: the verdict goes out right away
        if (frame_len == 32'h0) begin
            rx_phase = RX_HUNT;
            res = '{ev: checksum_event(), data: 8'h00, len: frame_len};
            return 1'b1;
        end
        rx_phase = RX_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit rx_step(input logic tick, input logic [7:0] c, output t_rx_result res);
        int unsigned need;
        int unsigned pos;
        int unsigned sum_next;
        logic [7:0]  want;
        res  = '{ev: EV_PAYLOAD, data: 8'h00, len: 32'h0};
        need = kind_reg ? NETDATA_LEN : DATA_LEN;

        // release the held verdict; a marker here opens the next frame
        if (rx_phase == RX_VERDICT) begin
            rx_phase = RX_HUNT;
            if (!tick && c == MARKER_BYTE) begin
                elapsed = '0;
                open_field(RX_TAG);
            end
            res = '{ev: checksum_event(), data: 8'h00, len: frame_len};
            return 1'b1;
        end

        if (tick) begin
            if (rx_phase == RX_HUNT)
                return 1'b0;
            if (elapsed != 16'hFFFF)
                elapsed++;
            if (elapsed >= timeout_reg) begin
                rx_phase = RX_HUNT;
                res = '{ev: EV_TIMEOUT, data: 8'h00, len: frame_len};
                return 1'b1;
            end
            return 1'b0;
        end

        case (rx_phase)
            RX_HUNT: begin
                if (c == MARKER_BYTE) begin
                    elapsed   = '0;
                    frame_len = '0;
                    frame_sum = '0;
                    open_field(RX_TAG);
                end
                return 1'b0;
            end
            RX_PAYLOAD: begin
                sum_next = pay_sum + c;
                if (sum_next > SUM_LIMIT)
                    sum_next = sum_next % SUM_LIMIT;
                pay_sum = sum_next[13:0];
                pay_cnt++;
                if (pay_cnt >= frame_len)
                    rx_phase = RX_VERDICT;
                res = '{ev: EV_PAYLOAD, data: c, len: 32'h0};
                return 1'b1;
            end
            default: ;
        endcase

        // header field: a zero or the byte past a full field ends it and is dropped
        if (c == 8'h00 || field_cnt >= FIELD_MAX - 1) begin
            case (rx_phase)
                RX_TAG: begin
                    if (tag_bad || field_cnt < need)
                        rx_phase = RX_HUNT;
                    else
                        open_field(RX_LEN);
                end
                RX_LEN: begin
                    frame_len = num_acc;
                    open_field(RX_SUM);
                end
                RX_SUM: begin
                    frame_sum = num_acc;
                    if (kind_reg)
                        open_field(RX_APP);
                    else
                        return begin_payload(res);
                end
                default: return begin_payload(res);
            endcase
            return 1'b0;
        end

        pos = field_cnt;
        field_cnt++;
        case (rx_phase)
            RX_TAG: begin
                if (pos < need) begin
                    want = kind_reg ? NETDATA_WORD[8*(6-pos) +: 8] : DATA_WORD[8*(3-pos) +: 8];
                    if (want != c)
                        tag_bad = 1'b1;
                end
            end
            RX_APP: begin
                if (pos < APP_MAX) begin
                    res = '{ev: EV_APP, data: c, len: 32'h0};
                    return 1'b1;
                end
            end
            default: begin
                if (!num_done && c >= CH_ZERO && c <= CH_NINE)
                    num_acc = num_acc * 32'd10 + (c - CH_ZERO);
                else
                    num_done = 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_req(input logic tick, input logic [7:0] b);
        int unsigned gap;
        t_rx_result  res;
        gap = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= tick;
        in_ch.rx_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        req_cnt++;
        if (rx_step(tick, b, res))
            expected_q.push_back(res);
    endtask

    task automatic send_ticked(input logic [7:0] b, input int unsigned tick_pct);
        if ($urandom_range(0, 99) < tick_pct)
            send_req(1'b1, 8'($urandom));
        send_req(1'b0, b);
    endtask

    task automatic send_noise(input int unsigned cnt);
        repeat (cnt) begin
            if ($urandom_range(0, 3) == 0)
                send_req(1'b1, 8'($urandom));
            else
                send_req(1'b0, ($urandom_range(0, 9) == 0) ? MARKER_BYTE : 8'($urandom));
        end
    endtask

    task automatic set_config(input logic kind, input logic [15:0] tmo);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_FRAME_KIND;
        cfg_ch.data  <= {15'd0, kind};
        do @(posedge clk); while (!cfg_ch.ready);
        kind_reg = kind;
        cfg_ch.index <= CFG_TIMEOUT;
        cfg_ch.data  <= tmo;
        do @(posedge clk); while (!cfg_ch.ready);
        timeout_reg = tmo;
        cfg_ch.valid <= 1'b0;
    endtask

    // drop valid, wait for every pending result, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic shuffle_idling();
        send_idle_on  = ($urandom_range(0, 3) != 0);
        recv_stall_on = ($urandom_range(0, 3) != 0);
    endtask

    // ---------------------------------------------------------------- frame building

    task automatic add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endtask

    task automatic close_field(ref logic [7:0] fr[$], ref logic [7:0] fld[$]);
        while (fld.size() > FIELD_MAX - 1)
            void'(fld.pop_back());
        foreach (fld[i])
            fr.push_back(fld[i]);
        // a full field ends on whatever byte comes next
        fr.push_back((fld.size() == FIELD_MAX - 1) ? 8'($urandom) : 8'h00);
        fld.delete();
    endtask

    task automatic add_number(ref logic [7:0] fld[$], input longint unsigned v);
        string      txt;
        logic [7:0] junk;
        txt = $sformatf("%0d", v);
        case ($urandom_range(0, 9))
            0: if (v != 0) add_text(fld, txt);
            1: begin
                while (txt.len() < FIELD_MAX - 1)
                    txt = {"0", txt};
                add_text(fld, txt);
            end
            2: begin
                add_text(fld, txt);
                do junk = 8'($urandom_range(1, 255)); while (junk >= CH_ZERO && junk <= CH_NINE);
                fld.push_back(junk);
                repeat ($urandom_range(0, 3)) fld.push_back(8'($urandom_range(1, 255)));
            end
            // wraps back to the same value modulo 2^32
            3: add_text(fld, $sformatf("%0d", v + 64'd4294967296));
            default: add_text(fld, txt);
        endcase
    endtask

    task automatic add_tag(ref logic [7:0] fld[$]);
        int unsigned pick;
        int unsigned pos;
        logic [7:0]  ch;
        pick = $urandom_range(0, 9);
        if (kind_reg ^ (pick == 0))
            add_text(fld, "NETDATA");
        else
            add_text(fld, "DATA");
        if (pick == 1) begin
            pos = $urandom_range(0, fld.size() - 1);
            do ch = 8'($urandom_range(1, 255)); while (ch == fld[pos]);
            fld[pos] = ch;
        end else if (pick == 2) begin
            repeat ($urandom_range(1, fld.size())) void'(fld.pop_back());
        end else begin
            repeat ($urandom_range(0, FIELD_MAX - 1 - fld.size()))
                fld.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_frame(input int unsigned tick_pct);
        logic [7:0]  fr[$];
        logic [7:0]  fld[$];
        logic [7:0]  body[$];
        int unsigned pick;
        int unsigned total;
        int unsigned n;
        pick = $urandom_range(0, 19);
        if (pick == 2) begin
            // long high-valued payload: the sum can wrap past the limit
            repeat ($urandom_range(40, 60)) body.push_back(8'($urandom_range(200, 255)));
        end else if (pick == 3) begin
            // land exactly on the limit, which is kept as is
            repeat (39) body.push_back(8'd255);
            body.push_back(8'd55);
            repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
        end else if (pick > 3) begin
            repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
        end
        total = 0;
        foreach (body[i]) begin
            total += body[i];
            if (total > SUM_LIMIT)
                total %= SUM_LIMIT;
        end
        if ($urandom_range(0, 4) == 0)
            total = ($urandom_range(0, 1) != 0) ? total + 1 : $urandom_range(0, 10255);

        fr.push_back(MARKER_BYTE);
        add_tag(fld);
        close_field(fr, fld);
        add_number(fld, body.size());
        close_field(fr, fld);
        add_number(fld, total);
        close_field(fr, fld);
        if (kind_reg) begin
            repeat ($urandom_range(0, FIELD_MAX - 1)) fld.push_back(8'($urandom_range(1, 255)));
            close_field(fr, fld);
        end
        frame_cnt++;
        foreach (fr[i])
            send_ticked(fr[i], tick_pct);
        // follow the length the block actually parsed
        n = 0;
        while (rx_phase == RX_PAYLOAD && n < body.size() + 16) begin
            send_ticked((n < body.size()) ? body[n] : 8'($urandom), tick_pct);
            n++;
        end
    endtask

    // ---------------------------------------------------------------- result checker

    always @(posedge clk) begin : check_proc
        t_rx_result exp_res;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                result_cnt++;
                if (expected_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("ERROR: result %0d with nothing pending: ev=%0d data=%02h len=%0d",
                                 result_cnt, out_ch.event_res, out_ch.data_byte,
                                 out_ch.frame_length);
                end else begin
                    exp_res = expected_q.pop_front();
                    case (exp_res.ev)
                        EV_GOOD:    good_cnt++;
                        EV_BAD:     bad_cnt++;
                        EV_TIMEOUT: tmo_cnt++;
                        default: ;
                    endcase
                    if (out_ch.event_res != exp_res.ev || out_ch.data_byte != exp_res.data
                            || out_ch.frame_length != exp_res.len) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX) begin
                            $display("ERROR: result %0d: expected ev=%0d data=%02h len=%0d",
                                     result_cnt, exp_res.ev, exp_res.data, exp_res.len);
                            $display("       got ev=%0d data=%02h len=%0d",
                                     out_ch.event_res, out_ch.data_byte, out_ch.frame_length);
                        end
                    end
                end
                hold_cnt = recv_stall_on ? $urandom_range(0, MAX_WAIT) : 0;
            end else if (hold_cnt != 0) begin
                hold_cnt--;
            end
            out_ch.ready <= (hold_cnt == 0);
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed_frames();
        logic [7:0] fr[$];
        set_config(1'b0, 16'hFFFF);
        send_req(1'b1, 8'hFF);
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'hFF);
        // empty length and checksum: verdict on the byte that ends the checksum
        fr.push_back(MARKER_BYTE);
        add_text(fr, "DATA");
        fr.push_back(8'h00);
        fr.push_back(8'h00);
        fr.push_back(8'h00);
        // one payload byte equal to the marker, verdict held for the next request
        fr.push_back(MARKER_BYTE);
        add_text(fr, "DATA");
        fr.push_back(8'h00);
        add_text(fr, "1");
        fr.push_back(8'h00);
        add_text(fr, "221");
        fr.push_back(8'h00);
        fr.push_back(MARKER_BYTE);
        foreach (fr[i])
            send_req(1'b0, fr[i]);
        send_req(1'b1, 8'h00);
        drain();
    endtask

    task automatic test_data_frames();
        int unsigned stop_at;
        set_config(1'b0, 16'($urandom_range(20, 2000)));
        stop_at = req_cnt + 100;
        while (req_cnt < stop_at) begin
            shuffle_idling();
            send_frame(5);
            if ($urandom_range(0, 7) == 0)
                send_noise($urandom_range(1, 4));
        end
        drain();
    endtask

    task automatic test_netdata_frames();
        int unsigned half_at;
        int unsigned stop_at;
        set_config(1'b1, TIMEOUT_RESET);
        half_at = req_cnt + 75;
        stop_at = req_cnt + 150;
        while (req_cnt < stop_at) begin
            shuffle_idling();
            send_frame(5);
            // hold the sender until the output side has caught up
            if (req_cnt >= half_at && half_at != 0) begin
                drain();
                half_at = 0;
            end
        end
        drain();
    endtask

    task automatic test_timeouts();
        int unsigned stop_at;
        logic        kind;
        kind = 1'($urandom_range(0, 1));
        set_config(kind, 16'd1);
        stop_at = req_cnt + 50;
        while (req_cnt < stop_at) begin
            shuffle_idling();
            send_frame(30);
        end
        drain();
        set_config(~kind, 16'($urandom_range(2, 6)));
        stop_at = req_cnt + 60;
        while (req_cnt < stop_at) begin
            shuffle_idling();
            send_frame(25);
        end
        drain();
    endtask

    task automatic test_noise_mix();
        int unsigned stop_at;
        set_config(1'b1, 16'hFFFF);
        stop_at = req_cnt + 60;
        while (req_cnt < stop_at) begin
            shuffle_idling();
            if ($urandom_range(0, 1) != 0)
                send_noise($urandom_range(3, 10));
            else
                send_frame(10);
        end
        drain();
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.cmd     = 1'b0;
        in_ch.rx_byte = 8'h00;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_FRAME_KIND;
        cfg_ch.data   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_data_frames();
        test_netdata_frames();
        test_timeouts();
        test_noise_mix();
        drain();

        $display("Sent %0d requests over %0d random frames, both frame kinds, timeouts 1 to 65535 ms.",
                 req_cnt, frame_cnt);
        $display("Checked %0d results: %0d good, %0d bad checksum, %0d timed out.",
                 result_cnt, good_cnt, bad_cnt, tmo_cnt);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatches: %0d", err_cnt);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
